/* rtl/core/dht_pkg.sv */
`default_nettype none
package dht_pkg;

    localparam int MAX_SLOTS_DEF = 128;
    localparam int KEY_W         = 16;
    localparam int SLOT_W        = 7;
    localparam int TS_W          = 8;
    localparam int OP_W          = 2;
    localparam int ST_W          = 2;
    localparam int MIN_SIZE      = 2;
    localparam logic [TS_W-1:0] TS_RESET = 8'd11;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd0;
    localparam logic [ST_W-1:0] ST_OCCUPIED = 2'd1;
    localparam logic [ST_W-1:0] ST_REMOVED  = 2'd2;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_OPCHK,
        S_DIV,
        S_PSET,
        S_RD,
        S_EVAL,
        S_MISS,
        S_LOOP,
        S_FAIL,
        S_OK,
        S_PUT
    } step_t;

    typedef enum logic [3:0] {
        A_NOP,
        A_CLEAR,
        A_READY,
        A_DIV_INIT,
        A_DIV_STEP,
        A_PROBE_INIT,
        A_READ,
        A_COMMIT,
        A_ADVANCE,
        A_SET_FAIL,
        A_SET_OK,
        A_PUSH
    } action_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_CLR_LAST,
        C_BAD_OP,
        C_DIV_LAST,
        C_HIT,
        C_MISS,
        C_PROBE_LAST,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        action_t act;
        cond_t   cond;
        step_t   on_true;
        step_t   on_false;
    } uword_t;

    typedef struct packed {
        logic accept;
        logic clr_last;
        logic bad_op;
        logic div_last;
        logic hit;
        logic miss;
        logic probe_last;
        logic out_free;
    } stat_t;

    // control store
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = '{A_NOP, C_ALWAYS, S_IDLE, S_IDLE};
        case (s)
            S_CLR:   w = '{A_CLEAR,      C_CLR_LAST,   S_IDLE, S_CLR};
            S_IDLE:  w = '{A_READY,      C_ACCEPT,     S_OPCHK, S_IDLE};
            S_OPCHK: w = '{A_DIV_INIT,   C_BAD_OP,     S_FAIL, S_DIV};
            S_DIV:   w = '{A_DIV_STEP,   C_DIV_LAST,   S_PSET, S_DIV};
            S_PSET:  w = '{A_PROBE_INIT, C_ALWAYS,     S_RD,   S_RD};
            S_RD:    w = '{A_READ,       C_ALWAYS,     S_EVAL, S_EVAL};
            S_EVAL:  w = '{A_COMMIT,     C_HIT,        S_OK,   S_MISS};
            S_MISS:  w = '{A_ADVANCE,    C_MISS,       S_FAIL, S_LOOP};
            S_LOOP:  w = '{A_NOP,        C_PROBE_LAST, S_FAIL, S_RD};
            S_FAIL:  w = '{A_SET_FAIL,   C_ALWAYS,     S_PUT,  S_PUT};
            S_OK:    w = '{A_SET_OK,     C_ALWAYS,     S_PUT,  S_PUT};
            S_PUT:   w = '{A_PUSH,       C_OUT_FREE,   S_IDLE, S_PUT};
            default: w = '{A_NOP,        C_ALWAYS,     S_IDLE, S_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/double_hash_table.sv */
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata: operation[1:0], key[17:2]
// m_axis    out  m_tvalid/m_tready  m_tdata: slot[6:0], result_code[7]
// cfg       in   cfg_we             cfg_wdata: table_size[7:0]
//
// One word at a time. Accept, op check, 16 remainder steps (one key bit
// per step for both hashes), probe setup, then read and evaluate per probe
// (slot RAM read is registered), advance and loop if no hit, result, push.
// After reset the status store is swept to empty, with no input taken.
// A stalled output holds the sequencer in its push step.
module double_hash_table #(
    parameter int MAX_SLOTS = dht_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [23:0]              s_tdata,    // operation[1:0], key[17:2]
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [7:0]               m_tdata,    // slot[6:0], result_code[7]
    input  wire logic                     cfg_we,
    input  wire logic [dht_pkg::TS_W-1:0] cfg_wdata
);
    import dht_pkg::*;

    action_t act;
    stat_t   stat;

    dht_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .act   (act)
    );

    dht_dpath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .act       (act),
        .stat      (stat),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule
`default_nettype wire

/* rtl/core/dht_ram.sv */
`default_nettype none
module dht_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/dht_seq.sv */
`default_nettype none
module dht_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dht_pkg::stat_t  stat,
    output dht_pkg::action_t     act
);
    import dht_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   cond_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_CLR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        uw = ucode(step_reg);
        unique case (uw.cond)
            C_ALWAYS:     cond_val = 1'b1;
            C_ACCEPT:     cond_val = stat.accept;
            C_CLR_LAST:   cond_val = stat.clr_last;
            C_BAD_OP:     cond_val = stat.bad_op;
            C_DIV_LAST:   cond_val = stat.div_last;
            C_HIT:        cond_val = stat.hit;
            C_MISS:       cond_val = stat.miss;
            C_PROBE_LAST: cond_val = stat.probe_last;
            C_OUT_FREE:   cond_val = stat.out_free;
            default:      cond_val = 1'b1;
        endcase
        step_next = cond_val ? uw.on_true : uw.on_false;
        act       = uw.act;
    end

endmodule
`default_nettype wire

/* rtl/core/dht_dpath.sv */
`default_nettype none
module dht_dpath #(
    parameter int MAX_SLOTS = dht_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dht_pkg::action_t         act,
    output dht_pkg::stat_t                stat,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [23:0]              s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [7:0]               m_tdata,
    input  wire logic                     cfg_we,
    input  wire logic [dht_pkg::TS_W-1:0] cfg_wdata
);
    import dht_pkg::*;

    localparam int AW  = $clog2(MAX_SLOTS);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int SW  = (CW > TS_W) ? CW : TS_W;
    localparam int DCW = $clog2(KEY_W);
    localparam int RW  = ST_W + KEY_W;

    logic [TS_W-1:0]   ts_reg;
    logic [OP_W-1:0]   op_reg,     op_next;
    logic [KEY_W-1:0]  key_reg,    key_next;
    logic [KEY_W-1:0]  ksh_reg,    ksh_next;
    logic [CW-1:0]     m_reg,      m_next;
    logic [CW-1:0]     r1_reg,     r1_next;
    logic [CW-1:0]     r2_reg,     r2_next;
    logic [DCW-1:0]    dcnt_reg,   dcnt_next;
    logic [AW-1:0]     pos_reg,    pos_next;
    logic [CW-1:0]     stride_reg, stride_next;
    logic [CW-1:0]     probe_reg,  probe_next;
    logic [SLOT_W-1:0] rslot_reg,  rslot_next;
    logic              rcode_reg,  rcode_next;
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        odata_reg,  odata_next;

    logic [SW-1:0]     ts_ext;
    logic [CW-1:0]     m_in;
    logic [CW-1:0]     dm1;
    logic [CW:0]       t1, t2, d1, d2;
    logic [CW:0]       psum;
    logic [CW:0]       pwrap;
    logic              accept;
    logic              out_free;
    logic [RW-1:0]     rdata;
    logic [ST_W-1:0]   rd_st;
    logic              occ;
    logic              hit;
    logic              ram_we;
    logic [RW-1:0]     ram_wdata;
    logic [AW+SLOT_W-1:0] slot_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= TS_RESET;
        end
        else if (cfg_we)
        begin
            ts_reg <= cfg_wdata;
        end
    end

    // clamp table size into [2, MAX_SLOTS]
    always_comb
    begin
        ts_ext = SW'(ts_reg);
        if (ts_ext < SW'(MIN_SIZE))
        begin
            m_in = CW'(MIN_SIZE);
        end
        else if (ts_ext > SW'(MAX_SLOTS))
        begin
            m_in = CW'(MAX_SLOTS);
        end
        else
        begin
            m_in = CW'(ts_ext);
        end
    end

    assign s_tready = (act == A_READY);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    // restoring remainder, one key bit per step, both moduli side by side
    assign dm1 = m_reg - CW'(1);
    assign t1  = {r1_reg, ksh_reg[KEY_W-1]};
    assign t2  = {r2_reg, ksh_reg[KEY_W-1]};
    assign d1  = (t1 >= (CW+1)'(m_reg)) ? t1 - (CW+1)'(m_reg) : t1;
    assign d2  = (t2 >= (CW+1)'(dm1)) ? t2 - (CW+1)'(dm1) : t2;

    // next probe; pos < m and stride < m so one subtract wraps it
    assign psum  = (CW+1)'(pos_reg) + (CW+1)'(stride_reg);
    assign pwrap = (psum >= (CW+1)'(m_reg)) ? psum - (CW+1)'(m_reg) : psum;

    assign rd_st = rdata[RW-1:KEY_W];
    assign occ   = (rd_st == ST_OCCUPIED);
    assign hit   = (op_reg == OP_INSERT) ? !occ : (occ && (rdata[KEY_W-1:0] == key_reg));

    assign slot_wide = (AW+SLOT_W)'(pos_reg);

    always_comb
    begin
        stat.accept     = accept;
        stat.clr_last   = (pos_reg == AW'(MAX_SLOTS - 1));
        stat.bad_op     = (op_reg != OP_INSERT) && (op_reg != OP_SEARCH)
                          && (op_reg != OP_REMOVE);
        stat.div_last   = (dcnt_reg == '0);
        stat.hit        = hit;
        stat.miss       = (op_reg != OP_INSERT) && (rd_st == ST_EMPTY);
        stat.probe_last = (probe_reg == m_reg);
        stat.out_free   = out_free;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = {ST_EMPTY, KEY_W'(0)};
        if (act == A_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (act == A_COMMIT && hit && op_reg != OP_SEARCH)
        begin
            ram_we = 1'b1;
            if (op_reg == OP_INSERT)
            begin
                ram_wdata = {ST_OCCUPIED, key_reg};
            end
            else
            begin
                ram_wdata = {ST_REMOVED, rdata[KEY_W-1:0]};
            end
        end
    end

    always_comb
    begin
        op_next     = op_reg;
        key_next    = key_reg;
        ksh_next    = ksh_reg;
        m_next      = m_reg;
        r1_next     = r1_reg;
        r2_next     = r2_reg;
        dcnt_next   = dcnt_reg;
        pos_next    = pos_reg;
        stride_next = stride_reg;
        probe_next  = probe_reg;
        rslot_next  = rslot_reg;
        rcode_next  = rcode_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (act)
            A_CLEAR:
            begin
                pos_next = pos_reg + AW'(1);
            end
            A_READY:
            begin
                if (accept)
                begin
                    op_next  = s_tdata[OP_W-1:0];
                    key_next = s_tdata[OP_W+KEY_W-1:OP_W];
                    ksh_next = s_tdata[OP_W+KEY_W-1:OP_W];
                    m_next   = m_in;
                end
            end
            A_DIV_INIT:
            begin
                r1_next   = '0;
                r2_next   = '0;
                dcnt_next = DCW'(KEY_W - 1);
            end
            A_DIV_STEP:
            begin
                r1_next   = d1[CW-1:0];
                r2_next   = d2[CW-1:0];
                ksh_next  = {ksh_reg[KEY_W-2:0], 1'b0};
                dcnt_next = dcnt_reg - DCW'(1);
            end
            A_PROBE_INIT:
            begin
                pos_next    = AW'(r1_reg);
                stride_next = r2_reg + CW'(1);
                probe_next  = '0;
            end
            A_ADVANCE:
            begin
                pos_next   = AW'(pwrap);
                probe_next = probe_reg + CW'(1);
            end
            A_SET_FAIL:
            begin
                rslot_next = '0;
                rcode_next = 1'b1;
            end
            A_SET_OK:
            begin
                rslot_next = slot_wide[SLOT_W-1:0];
                rcode_next = 1'b0;
            end
            A_PUSH:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {rcode_reg, rslot_reg};
                end
            end
            A_NOP, A_READ, A_COMMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        ksh_reg    <= ksh_next;
        m_reg      <= m_next;
        r1_reg     <= r1_next;
        r2_reg     <= r2_next;
        dcnt_reg   <= dcnt_next;
        stride_reg <= stride_next;
        probe_reg  <= probe_next;
        rslot_reg  <= rslot_next;
        rcode_reg  <= rcode_next;
        odata_reg  <= odata_next;
    end

    // slot word: status in the top bits, key below
    dht_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (ram_wdata),
        .re    (act == A_READ),
        .raddr (pos_reg),
        .rdata (rdata)
    );

endmodule
`default_nettype wire
